// ----- hdl/wmse_pkg.sv -----
// Shared widths and register codes of the windowed mean and deviation estimator.
package wmse_pkg;

  localparam int SAMPLE_W = 24;
  localparam int FACTOR_W = 20;
  localparam int VAR_W    = 2 * SAMPLE_W;
  localparam int FRAC_SH  = 16;
  localparam int FLR_W    = SAMPLE_W + FACTOR_W - FRAC_SH;
  localparam int OUT_W    = 56;
  localparam int OUT_PAD  = OUT_W - 2 * SAMPLE_W - 2;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  typedef enum logic {
    REG_LEARN  = 1'b0,
    REG_FACTOR = 1'b1
  } reg_idx_e;

endpackage

// ----- hdl/wmse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wmse_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/windowed_mean_std_estimator.sv -----
// Sliding window of samples with running mean and floored standard deviation.
// One request is taken at a time. With learning on, a request passes the same
// steps for any WINDOW: window update, division and square root; the block is
// ready again in the same cycle that its result appears. With learning off the
// window update is skipped. A result still held at the output delays the next
// one until it is taken. The time is set by the bit-serial square root, one root
// bit per cycle, and by the division of the square sum by WINDOW, a multiplication
// by its reciprocal in four partial products, one per cycle.
// Reset leaves the window empty (all zero) without a clearing pass: entries
// count as zero until the write pointer has gone once around the ring.
module windowed_mean_std_estimator
  import wmse_pkg::*;
#(
  parameter int WINDOW = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // sample [23:0]
  input  logic [23:0]       s_axis_tdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // window_mean [23:0], std_dev [47:24], floor_applied [48], updated [49], zero [55:50]
  output logic [OUT_W-1:0]  m_axis_tdata_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o
);

  localparam int AW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LGW     = $clog2(WINDOW);
  localparam int SUM_W   = SAMPLE_W + LGW;
  localparam int SQ_W    = VAR_W + LGW;
  localparam int RCP_W   = SQ_W + 1;
  localparam int HX      = (SQ_W + 1) / 2;
  localparam int HM      = (RCP_W + 1) / 2;
  localparam int PP_W    = HX + HM;
  localparam int ACC_W   = SQ_W + RCP_W;
  localparam int PP_CNT  = 4;
  localparam int CNT_W   = $clog2(SAMPLE_W + 1);
  localparam int REM_W   = SAMPLE_W + 2;

  // floor(x / WINDOW) == (x * RCP) >> (N + LGW) for every N-bit x
  localparam logic [SUM_W:0]     RCP_SUM  = (SUM_W + 1)'(
      ((128'd1 << (SUM_W + LGW)) / 128'(WINDOW)) + 128'd1);
  localparam logic [RCP_W-1:0]   RCP_SQ   = RCP_W'(
      ((128'd1 << (SQ_W + LGW)) / 128'(WINDOW)) + 128'd1);
  localparam logic [AW-1:0]      POS_LAST = AW'(WINDOW - 1);
  localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(PP_CNT - 1);
  localparam logic [CNT_W-1:0]   ROOT_LAST = CNT_W'(SAMPLE_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQR, ST_ACC, ST_LOAD, ST_DIV, ST_MUL, ST_VAR, ST_ROOT, ST_FIN
  } state_e;

  state_e                 state_q;
  logic                   learn_q;
  logic [FACTOR_W-1:0]    factor_q;
  logic [AW-1:0]          pos_q;
  logic                   wrapped_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SQ_W-1:0]        sq_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SAMPLE_W-1:0]    sample_q;
  logic                   upd_q;
  logic [VAR_W-1:0]       old_sq_q;
  logic [VAR_W-1:0]       new_sq_q;
  logic [ACC_W-1:0]       acc_q;
  logic [SAMPLE_W-1:0]    mean_q;
  logic [VAR_W-1:0]       msq_q;
  logic [VAR_W-1:0]       mm_q;
  logic [SAMPLE_W-1:0]    flr_q;
  logic [VAR_W-1:0]       var_q;
  logic [REM_W-1:0]       root_rem_q;
  logic [SAMPLE_W-1:0]    root_q;
  logic                   m_valid_q;
  logic [SAMPLE_W-1:0]    out_mean_q;
  logic [SAMPLE_W-1:0]    out_std_q;
  logic                   out_flr_q;
  logic                   out_upd_q;

  logic [SAMPLE_W-1:0]    ram_rdata;
  logic                   ram_we;
  logic [SAMPLE_W-1:0]    old_val;
  logic                   cfg_we;
  logic [2*SUM_W:0]       sum_prod;
  logic [HX-1:0]          mul_a;
  logic [HM-1:0]          mul_b;
  logic [PP_W-1:0]        pp;
  logic [ACC_W-1:0]       pp_sh;
  logic [REM_W+1:0]       root_try;
  logic [REM_W+1:0]       root_sub;
  logic [REM_W-1:0]       root_rem_d;
  logic [SAMPLE_W-1:0]    root_d;
  logic [SAMPLE_W+FACTOR_W-1:0] flr_prod;
  logic [FLR_W-1:0]       flr_sh;
  logic                   out_free;

  wmse_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(sample_q),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  assign ram_we  = (state_q == ST_SQR);
  assign old_val = wrapped_q ? ram_rdata : '0;
  assign cfg_we  = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign prdata_o = (reg_idx_e'(paddr_i[2]) == REG_FACTOR) ?
                    APB_DW'(factor_q) : APB_DW'(learn_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, out_upd_q, out_flr_q, out_std_q, out_mean_q};
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign sum_prod = (2 * SUM_W + 1)'(sum_q) * (2 * SUM_W + 1)'(RCP_SUM);

  // square sum times the reciprocal of WINDOW, one partial product per cycle
  assign mul_a = cnt_q[0] ? HX'(sq_q[SQ_W-1:HX]) : sq_q[HX-1:0];
  assign mul_b = cnt_q[1] ? HM'(RCP_SQ[RCP_W-1:HM]) : RCP_SQ[HM-1:0];
  assign pp    = PP_W'(mul_a) * PP_W'(mul_b);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_sh = ACC_W'(pp);
      2'd1:    pp_sh = ACC_W'(pp) << HX;
      2'd2:    pp_sh = ACC_W'(pp) << HM;
      default: pp_sh = ACC_W'(pp) << (HX + HM);
    endcase
  end

  // one root bit per cycle
  always_comb begin
    root_try   = {root_rem_q, var_q[VAR_W-1 -: 2]};
    root_sub   = (REM_W + 2)'({root_q, 2'b01});
    root_rem_d = REM_W'((root_try >= root_sub) ? root_try - root_sub : root_try);
    root_d     = {root_q[SAMPLE_W-2:0], (root_try >= root_sub)};
  end

  assign flr_prod = (SAMPLE_W + FACTOR_W)'(mean_q) * (SAMPLE_W + FACTOR_W)'(factor_q);
  assign flr_sh   = flr_prod[SAMPLE_W+FACTOR_W-1:FRAC_SH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      learn_q   <= 1'b1;
      factor_q  <= '0;
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      sum_q     <= '0;
      sq_q      <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_e'(paddr_i[2]))
          REG_LEARN:  learn_q  <= pwdata_i[0];
          REG_FACTOR: factor_q <= pwdata_i[FACTOR_W-1:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready_i && state_q != ST_FIN) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            sample_q <= s_axis_tdata_i;
            upd_q    <= learn_q;
            state_q  <= learn_q ? ST_SQR : ST_LOAD;
          end
        end
        ST_SQR: begin
          old_sq_q  <= VAR_W'(old_val) * VAR_W'(old_val);
          new_sq_q  <= VAR_W'(sample_q) * VAR_W'(sample_q);
          sum_q     <= sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
          pos_q     <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
          wrapped_q <= wrapped_q | (pos_q == POS_LAST);
          state_q   <= ST_ACC;
        end
        ST_ACC: begin
          sq_q    <= sq_q - SQ_W'(old_sq_q) + SQ_W'(new_sq_q);
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          mean_q  <= sum_prod[SUM_W+LGW +: SAMPLE_W];
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          acc_q <= acc_q + pp_sh;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_LAST) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          msq_q   <= acc_q[SQ_W+LGW +: VAR_W];
          mm_q    <= VAR_W'(mean_q) * VAR_W'(mean_q);
          flr_q   <= (|flr_sh[FLR_W-1:SAMPLE_W]) ? '1 : flr_sh[SAMPLE_W-1:0];
          state_q <= ST_VAR;
        end
        ST_VAR: begin
          var_q      <= (msq_q > mm_q) ? msq_q - mm_q : '0;
          root_rem_q <= '0;
          root_q     <= '0;
          cnt_q      <= '0;
          state_q    <= ST_ROOT;
        end
        ST_ROOT: begin
          root_rem_q <= root_rem_d;
          root_q     <= root_d;
          var_q      <= {var_q[VAR_W-3:0], 2'b00};
          cnt_q      <= cnt_q + 1'b1;
          if (cnt_q == ROOT_LAST) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_mean_q <= mean_q;
            out_std_q  <= (root_q < flr_q) ? flr_q : root_q;
            out_flr_q  <= (root_q < flr_q);
            out_upd_q  <= upd_q;
            m_valid_q  <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_ram_write_learn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> upd_q)
    else $error("history written by a request with learning off");

  a_wrap_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wrapped_q) |-> pos_q == '0)
    else $error("ring marked full away from its start");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> root_rem_q <= REM_W'({root_q, 1'b0}))
    else $error("square root remainder too large");

endmodule
